// ===== hw/rtl/rrpb_pkg.sv =====
// ----------------------------------------------------------------------------
// rrpb_pkg
// Shared widths, default sizes, operation/status codes and the sequencer
// state encoding for the round-robin pipe balancer.
// ----------------------------------------------------------------------------
`default_nettype none

package rrpb_pkg;

  localparam int MAX_OUTLETS_DEF = 16;
  localparam int ID_W            = 4;
  localparam int MASK_W          = 16;
  localparam int FUNC_W          = 3;
  localparam int STATUS_W        = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEND       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PROBE      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ACTIVATE   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DEACTIVATE = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BLOCK    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUP_FULL = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_START  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_TAIL   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/round_robin_pipe_balancer.sv =====
// ----------------------------------------------------------------------------
// round_robin_pipe_balancer
// Move-to-back round-robin outlet balancer: ordered member list in a small
// memory, walked one entry per cycle by a sequencer.
// ----------------------------------------------------------------------------
// One item at a time. Add, activate, deactivate and unused codes do not
// walk the list. Send and probe on a non-empty list, and remove of a
// member, walk the order list through its single read port, one entry per
// cycle; send on a ready entry and remove then rotate that entry to the
// back one entry per cycle. A new item is taken once the result is loaded
// into the output register, even if it is still waiting to be taken.
`default_nettype none

module round_robin_pipe_balancer #(
  parameter int MAX_OUTLETS = rrpb_pkg::MAX_OUTLETS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rrpb_pkg::FUNC_W-1:0]   func,
  input  wire logic [rrpb_pkg::ID_W-1:0]     pipe_id,
  input  wire logic [rrpb_pkg::MASK_W-1:0]   ready_mask,
  input  wire logic [rrpb_pkg::MASK_W-1:0]   error_mask,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rrpb_pkg::STATUS_W-1:0]      status,
  output logic [rrpb_pkg::ID_W-1:0]          chosen_pipe,
  output logic                               can_send,
  output logic [rrpb_pkg::MASK_W-1:0]        active_flags
);
  import rrpb_pkg::*;

  localparam int IDX_W = (MAX_OUTLETS > 1) ? $clog2(MAX_OUTLETS) : 1;
  localparam int CNT_W = $clog2(MAX_OUTLETS + 1);

  state_t              state;
  logic [FUNC_W-1:0]   op;
  logic [ID_W-1:0]     pid;
  logic [MASK_W-1:0]   rdy;
  logic [MASK_W-1:0]   err;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    count;
  logic [MASK_W-1:0]   member_mask;
  logic [MASK_W-1:0]   active_mask;
  logic [ID_W-1:0]     mover;
  logic [STATUS_W-1:0] st;
  logic [ID_W-1:0]     chosen;
  logic                can;

  logic [ID_W-1:0]     order_list [MAX_OUTLETS];
  logic [ID_W-1:0]     rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [ID_W-1:0]     wr_data;

  logic [CNT_W-1:0]    idx_p1;
  logic [CNT_W-1:0]    cnt_m1;
  logic                at_last;
  logic                add_bad;
  logic                hit;
  logic                stop_err;
  logic                is_send;
  logic                is_probe;
  logic                is_remove;
  logic                start_walk;

  assign in_stall   = (state != ST_IDLE);
  assign idx_p1     = CNT_W'(idx) + CNT_W'(1);
  assign cnt_m1     = count - CNT_W'(1);
  assign at_last    = (idx_p1 == count);
  assign add_bad    = member_mask[pid] || (count >= CNT_W'(MAX_OUTLETS));
  assign is_send    = (op == FUNC_SEND);
  assign is_probe   = (op == FUNC_PROBE);
  assign is_remove  = (op == FUNC_REMOVE);
  assign start_walk = (is_remove && member_mask[pid]) ||
                      ((is_send || is_probe) && (count != '0));

  always_comb begin
    hit      = 1'b0;
    stop_err = 1'b0;
    if (is_remove) begin
      hit = (rd_data == pid);
    end else if (is_send) begin
      hit      = rdy[rd_data];
      stop_err = err[rd_data];
    end else if (is_probe) begin
      hit = rdy[rd_data];
    end
  end

  always_comb begin
    rd_addr = idx;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    case (state)
      ST_START: begin
        rd_addr = '0;
        if (op == FUNC_ADD && !add_bad) begin
          wr_en   = 1'b1;
          wr_addr = count[IDX_W-1:0];
          wr_data = pid;
        end
      end
      ST_SCAN: begin
        rd_addr = idx_p1[IDX_W-1:0];
        if (hit && !is_probe && at_last) begin
          wr_en = 1'b1;
        end
      end
      ST_SHIFT: begin
        rd_addr = IDX_W'(idx_p1 + CNT_W'(1));
        wr_en   = 1'b1;
      end
      ST_TAIL: begin
        wr_en   = 1'b1;
        wr_data = mover;
      end
      default: begin
        rd_addr = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= order_list[rd_addr];
    if (wr_en) begin
      order_list[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      member_mask <= '0;
      active_mask <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op    <= func;
            pid   <= pipe_id;
            rdy   <= ready_mask;
            err   <= error_mask;
            state <= ST_START;
          end
        end
        ST_START: begin
          st     <= is_send ? STATUS_BLOCK :
                    ((op == FUNC_ADD && add_bad) ? STATUS_DUP_FULL : STATUS_OK);
          chosen <= '0;
          can    <= 1'b0;
          idx    <= '0;
          state  <= start_walk ? ST_SCAN : ST_FINISH;
          case (op)
            FUNC_ADD: begin
              if (!add_bad) begin
                count            <= count + CNT_W'(1);
                member_mask[pid] <= 1'b1;
                active_mask[pid] <= 1'b0;
              end
            end
            FUNC_REMOVE: begin
              if (member_mask[pid]) begin
                member_mask[pid] <= 1'b0;
              end
            end
            FUNC_ACTIVATE: begin
              active_mask[pid] <= 1'b1;
            end
            FUNC_DEACTIVATE: begin
              active_mask[pid] <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        ST_SCAN: begin
          if (hit) begin
            mover <= rd_data;
            if (!is_remove) begin
              active_mask[rd_data] <= 1'b1;
            end
            if (is_send) begin
              st     <= STATUS_OK;
              chosen <= rd_data;
            end
            if (is_probe) begin
              can   <= 1'b1;
              state <= ST_FINISH;
            end else if (at_last) begin
              if (is_remove) begin
                count <= cnt_m1;
              end
              state <= ST_FINISH;
            end else begin
              state <= ST_SHIFT;
            end
          end else if (stop_err) begin
            st     <= STATUS_ERROR;
            chosen <= rd_data;
            state  <= ST_FINISH;
          end else begin
            if (!is_remove) begin
              active_mask[rd_data] <= 1'b0;
            end
            idx <= idx_p1[IDX_W-1:0];
            if (at_last) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_SHIFT: begin
          idx <= idx_p1[IDX_W-1:0];
          if (idx_p1 == cnt_m1) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (is_remove) begin
            count <= cnt_m1;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            status       <= st;
            chosen_pipe  <= chosen;
            can_send     <= can;
            active_flags <= active_mask;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_round_robin_pipe_balancer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_pipe_balancer
// Self-checking bench for the move-to-back outlet balancer. Directed items
// cover the empty list, a full list, duplicate adds and the walk's edge
// cases. Random traffic then grows, shrinks and churns the member list. A
// local predictor computes each result, and a checker compares every result
// field by field. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_round_robin_pipe_balancer;
  import rrpb_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     chosen_pipe;
    logic                can_send;
    logic [MASK_W-1:0]   active_flags;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  func = FUNC_ADD;
  logic [ID_W-1:0]    pipe_id = '0;
  logic [MASK_W-1:0]  ready_mask = '0;
  logic [MASK_W-1:0]  error_mask = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]    chosen_pipe;
  logic               can_send;
  logic [MASK_W-1:0]  active_flags;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;
  localparam int DRAIN_CYCLES = 40;

  round_robin_pipe_balancer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .pipe_id     (pipe_id),
    .ready_mask  (ready_mask),
    .error_mask  (error_mask),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .chosen_pipe (chosen_pipe),
    .can_send    (can_send),
    .active_flags(active_flags)
  );

  // predictor state
  logic [ID_W-1:0]   model_order [MAX_OUTLETS_DEF];
  int                model_count = 0;
  logic [MASK_W-1:0] model_members = '0;
  logic [MASK_W-1:0] model_active = '0;

  outcome_t pending_outcomes[$];
  int       err_count = 0;
  bit       no_gaps = 1'b0;
  int       stall_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_round_robin_pipe_balancer: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = 16'h1 << $urandom_range(0, 15);
      2: m = (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
      3: m = $urandom & $urandom & $urandom;
      4: m = $urandom;
      default: m = '1;
    endcase
    return m;
  endfunction

  function void rotate_to_back(int pos);
    logic [ID_W-1:0] id;
    id = model_order[pos];
    for (int k = pos; k + 1 < model_count; k++) model_order[k] = model_order[k + 1];
    model_order[model_count - 1] = id;
  endfunction

  function outcome_t balance_step(logic [FUNC_W-1:0] f, logic [ID_W-1:0] pid,
                                  logic [MASK_W-1:0] rdy, logic [MASK_W-1:0] err);
    outcome_t o;
    logic [MASK_W-1:0] b;
    o = '0;
    o.status = STATUS_OK;
    case (f)
      FUNC_ADD: begin
        b = 16'h1 << pid;
        if ((model_members & b) != 0 || model_count >= MAX_OUTLETS_DEF) begin
          o.status = STATUS_DUP_FULL;
        end else begin
          model_order[model_count] = pid;
          model_count++;
          model_members |= b;
          model_active &= ~b;
        end
      end
      FUNC_REMOVE: begin
        b = 16'h1 << pid;
        if ((model_members & b) != 0) begin
          for (int k = 0; k < model_count; k++) begin
            if (model_order[k] == pid) begin
              rotate_to_back(k);
              model_count--;
              break;
            end
          end
          model_members &= ~b;
        end
      end
      FUNC_SEND: begin
        o.status = STATUS_BLOCK;
        for (int k = 0; k < model_count; k++) begin
          logic [ID_W-1:0] id;
          id = model_order[k];
          b = 16'h1 << id;
          if ((rdy & b) != 0) begin
            model_active |= b;
            rotate_to_back(k);
            o.status = STATUS_OK;
            o.chosen_pipe = id;
            break;
          end
          if ((err & b) != 0) begin
            o.status = STATUS_ERROR;
            o.chosen_pipe = id;
            break;
          end
          model_active &= ~b;
        end
      end
      FUNC_PROBE: begin
        for (int k = 0; k < model_count; k++) begin
          b = 16'h1 << model_order[k];
          if ((rdy & b) != 0) begin
            model_active |= b;
            o.can_send = 1'b1;
            break;
          end
          model_active &= ~b;
        end
      end
      FUNC_ACTIVATE:   model_active |= (16'h1 << pid);
      FUNC_DEACTIVATE: model_active &= ~(16'h1 << pid);
      default: ;
    endcase
    o.active_flags = model_active;
    return o;
  endfunction

  // one item; valid stays high into the next item when no gap is drawn
  task automatic send_item(logic [FUNC_W-1:0] f, logic [ID_W-1:0] pid,
                           logic [MASK_W-1:0] rdy, logic [MASK_W-1:0] err);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    pipe_id    <= pid;
    ready_mask <= rdy;
    error_mask <= err;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(balance_step(f, pid, rdy, err));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    int k;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      k = pick_gap();
      if (k > 0) begin
        stall_left <= k - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    outcome_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{status, chosen_pipe, can_send, active_flags};
      if (pending_outcomes.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result: %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got.status !== want.status || got.chosen_pipe !== want.chosen_pipe ||
            got.can_send !== want.can_send || got.active_flags !== want.active_flags) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected status %0d pipe %0d can %0d flags %h, got %0d %0d %0d %h",
                     want.status, want.chosen_pipe, want.can_send, want.active_flags,
                     got.status, got.chosen_pipe, got.can_send, got.active_flags);
        end
      end
    end
  end

  task automatic test_empty_list();
    send_item(FUNC_SEND, 4'd0, '1, '1);
    send_item(FUNC_PROBE, 4'd0, '1, '0);
    send_item(FUNC_REMOVE, 4'd9, '0, '0);
    send_item(FUNC_ACTIVATE, 4'd15, '0, '1);
    send_item(FUNC_UNUSED_7, 4'd15, '1, '1);
  endtask

  task automatic test_fill_list();
    for (int i = 0; i < MAX_OUTLETS_DEF; i++) send_item(FUNC_ADD, i[ID_W-1:0], '0, '0);
    send_item(FUNC_ADD, 4'd5, '0, '0);
  endtask

  task automatic test_walk_cases();
    send_item(FUNC_SEND, 4'd0, '0, '0);
    send_item(FUNC_SEND, 4'd0, '0, '1);
    send_item(FUNC_SEND, 4'd0, '1, '0);
    send_item(FUNC_PROBE, 4'd0, 16'h8000, '1);
    send_item(FUNC_DEACTIVATE, 4'd0, '0, '0);
    send_item(FUNC_UNUSED_6, 4'd0, '0, '0);
    send_item(FUNC_REMOVE, 4'd7, '0, '0);
  endtask

  task automatic test_random_traffic(int rounds, int per_round);
    int add_w;
    int r;
    logic [FUNC_W-1:0] f;
    logic [ID_W-1:0] pid;
    for (int rd = 0; rd < rounds; rd++) begin
      case (rd % 3)
        0: add_w = 35;
        1: add_w = 8;
        default: add_w = 22;
      endcase
      no_gaps = (rd == 4);
      for (int i = 0; i < per_round; i++) begin
        r = $urandom_range(0, 99);
        pid = $urandom_range(0, 15);
        if (r < add_w) f = FUNC_ADD;
        else if (r < 45) begin
          f = FUNC_REMOVE;
          if (model_count > 0 && $urandom_range(0, 4) != 0)
            pid = model_order[$urandom_range(0, model_count - 1)];
        end
        else if (r < 75) f = FUNC_SEND;
        else if (r < 85) f = FUNC_PROBE;
        else if (r < 91) f = FUNC_ACTIVATE;
        else if (r < 97) f = FUNC_DEACTIVATE;
        else f = $urandom_range(0, 1) ? FUNC_UNUSED_6 : FUNC_UNUSED_7;
        send_item(f, pid, pick_mask(), pick_mask());
      end
      if (rd == 5) drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_fill_list();
    test_walk_cases();
    drain();
    test_random_traffic(10, 200);
    drain();
    if (pending_outcomes.size() > 0) err_count++;
    if (err_count == 0) begin
      $display("tb_round_robin_pipe_balancer: done, clean");
    end else begin
      $display("tb_round_robin_pipe_balancer: done, errors");
    end
    $finish;
  end

endmodule
